FILE: rtl/adbe_pkg.sv
package adbe_pkg;

	localparam int FRAC_BITS_DEF = 23;
	localparam int SAMPLE_W      = 32;
	localparam int PCM_W         = 16;
	localparam int DIFF_W        = PCM_W + 1;
	localparam int DELTA_W       = 15;
	localparam int BYTE_W        = 8;

	localparam logic MODE_RAW  = 1'b0;
	localparam logic MODE_DPCM = 1'b1;

	localparam logic signed [DIFF_W-1:0]  DELTA_MAX = DIFF_W'(16383);
	localparam logic signed [DIFF_W-1:0]  DELTA_MIN = DIFF_W'(-16384);
	localparam logic signed [DELTA_W-1:0] SHORT_MAX = DELTA_W'(63);
	localparam logic signed [DELTA_W-1:0] SHORT_MIN = DELTA_W'(-64);
	localparam logic [BYTE_W-1:0]         CONT_BIT  = 8'h80;

	typedef struct packed {
		logic [BYTE_W-1:0]       b0;
		logic [BYTE_W-1:0]       b1;
		logic                    two;
		logic                    upd;
		logic signed [PCM_W-1:0] nxt;
	} enc_t;

endpackage

FILE: rtl/audio_dpcm_byte_encoder.sv
// Audio DPCM byte encoder. Each input word is a signed fixed-point sample
// (1.0 = 2^FRAC_BITS), scaled to 16 bits with truncation toward zero and
// saturation; clipped flags saturation on every byte of that sample. Mode 0
// sends two little-endian bytes per sample. Mode 1 (reset) sends a sample that
// starts a channel block raw in two bytes, and otherwise the difference from
// the last sent value clamped to -16384..16383: one byte for -64..63, else a
// byte with bit 7 set holding the low 7 bits followed by bits 14..7.
// last_byte marks the final byte of a sample. The first output byte passes
// through the input stage register and then the output register, which it
// enters once free. The byte-wide output register sets the rate: one byte per
// cycle while out_ready is high. Write mode only while the block is idle.
module audio_dpcm_byte_encoder #(
	parameter int FRAC_BITS = adbe_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [adbe_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 first_of_block,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [adbe_pkg::BYTE_W-1:0]          out_byte,
	output logic                                 last_byte,
	output logic                                 clipped
);

	logic                                 mode_q;
	logic signed [adbe_pkg::PCM_W-1:0]    lst_q;
	logic                                 vld_s1;
	logic signed [adbe_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                 first_s1;
	logic [1:0]                           cnt_q;
	logic [adbe_pkg::BYTE_W-1:0]          ob0_q;
	logic [adbe_pkg::BYTE_W-1:0]          ob1_q;
	logic                                 clip_q;

	logic signed [adbe_pkg::PCM_W-1:0]    pcm;
	logic                                 clip;
	adbe_pkg::enc_t                       enc;
	logic                                 load;
	logic                                 pop;
	logic                                 in_acc;

	adbe_scale #(
		.FRAC_BITS(FRAC_BITS)
	) u_scale (
		.sample(sample_s1),
		.pcm   (pcm),
		.clip  (clip)
	);

	adbe_enc u_enc (
		.pcm  (pcm),
		.lst  (lst_q),
		.first(first_s1),
		.mode (mode_q),
		.enc  (enc)
	);

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign load      = vld_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready));
	assign in_ready  = !vld_s1 || load;
	assign in_acc    = in_valid && in_ready;

	assign out_byte  = ob0_q;
	assign last_byte = (cnt_q == 2'd1);
	assign clipped   = clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= adbe_pkg::MODE_DPCM;
			lst_q  <= '0;
			vld_s1 <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (load && enc.upd) begin
				lst_q <= enc.nxt;
			end
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (load) begin
				vld_s1 <= 1'b0;
			end
			if (load) begin
				cnt_q <= enc.two ? 2'd2 : 2'd1;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= sample;
			first_s1  <= first_of_block;
		end
		if (load) begin
			ob0_q  <= enc.b0;
			ob1_q  <= enc.b1;
			clip_q <= clip;
		end else if (pop) begin
			ob0_q <= ob1_q;
		end
	end

`ifndef SYNTHESIS
	a_second_byte_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_byte) |=> (out_valid && last_byte))
		else $error("second byte of a word missing");

	a_raw_keeps_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && mode_q == adbe_pkg::MODE_RAW) |=> $stable(lst_q))
		else $error("tracked value changed in raw mode");

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && in_ready) |-> ((cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready)))
		else $error("input taken while output buffer full");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output byte count out of range");
`endif

endmodule

FILE: rtl/adbe_scale.sv
module adbe_scale #(
	parameter int FRAC_BITS = adbe_pkg::FRAC_BITS_DEF
) (
	input  logic signed [adbe_pkg::SAMPLE_W-1:0] sample,
	output logic signed [adbe_pkg::PCM_W-1:0]    pcm,
	output logic                                 clip
);

	localparam int SW = adbe_pkg::SAMPLE_W;
	localparam int K  = FRAC_BITS - 15;
	localparam logic signed [SW-1:0] HI  = SW'(longint'(32767) * (longint'(1) << K));
	localparam logic signed [SW-1:0] LO  = SW'(longint'(-32768) * (longint'(1) << K));
	localparam logic signed [SW-1:0] RND = SW'((longint'(1) << K) - longint'(1));

	logic signed [SW-1:0] biased;
	logic signed [SW-1:0] shifted;

	// truncate toward zero: bias negatives before the arithmetic shift
	assign biased  = sample[SW-1] ? (sample + RND) : sample;
	assign shifted = biased >>> K;

	always_comb begin
		clip = 1'b0;
		pcm  = shifted[adbe_pkg::PCM_W-1:0];
		if (sample > HI) begin
			clip = 1'b1;
			pcm  = adbe_pkg::PCM_W'(32767);
		end else if (sample < LO) begin
			clip = 1'b1;
			pcm  = adbe_pkg::PCM_W'(-32768);
		end
	end

endmodule

FILE: rtl/adbe_enc.sv
module adbe_enc (
	input  logic signed [adbe_pkg::PCM_W-1:0] pcm,
	input  logic signed [adbe_pkg::PCM_W-1:0] lst,
	input  logic                              first,
	input  logic                              mode,
	output adbe_pkg::enc_t                    enc
);

	logic signed [adbe_pkg::DIFF_W-1:0]  diff;
	logic signed [adbe_pkg::DIFF_W-1:0]  dcl;
	logic signed [adbe_pkg::DELTA_W-1:0] d;
	logic                                small_d;

	assign diff = adbe_pkg::DIFF_W'(pcm) - adbe_pkg::DIFF_W'(lst);

	always_comb begin
		if (diff > adbe_pkg::DELTA_MAX) begin
			dcl = adbe_pkg::DELTA_MAX;
		end else if (diff < adbe_pkg::DELTA_MIN) begin
			dcl = adbe_pkg::DELTA_MIN;
		end else begin
			dcl = diff;
		end
	end

	assign d       = dcl[adbe_pkg::DELTA_W-1:0];
	assign small_d = (d >= adbe_pkg::SHORT_MIN) && (d <= adbe_pkg::SHORT_MAX);

	always_comb begin
		enc     = '0;
		enc.nxt = lst + adbe_pkg::PCM_W'(d);
		enc.upd = 1'b1;
		if (mode == adbe_pkg::MODE_RAW || first) begin
			enc.b0  = pcm[7:0];
			enc.b1  = pcm[15:8];
			enc.two = 1'b1;
			enc.upd = (mode == adbe_pkg::MODE_DPCM);
			enc.nxt = pcm;
		end else if (small_d) begin
			enc.b0  = {1'b0, d[6:0]};
			enc.two = 1'b0;
		end else begin
			enc.b0  = adbe_pkg::CONT_BIT | {1'b0, d[6:0]};
			enc.b1  = d[14:7];
			enc.two = 1'b1;
		end
	end

endmodule
